>>> design/ffba_pkg.sv
// shared constants, widths, codes and the table entry type of the first-fit allocator
// no dependencies; used by first_fit_block_allocator
package ffba_pkg;

    // heap geometry
    localparam int HEAP_BYTES   = 16384;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 256;

    // field widths fixed by the stream words
    localparam int FIELD_W = 14;

    // derived widths
    localparam int START_W = $clog2(HEAP_BYTES);
    localparam int TOP_W   = $clog2(HEAP_BYTES + 1);
    localparam int PAY_W   = START_W + 1;
    localparam int CMP_W   = (PAY_W > FIELD_W) ? PAY_W : FIELD_W;
    localparam int SUM_W   = ((TOP_W > FIELD_W) ? TOP_W : FIELD_W) + 2;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);

    // stream word widths
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ZERO    = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;
    localparam logic [1:0] STAT_UNKNOWN = 2'd3;

    // one block table entry
    typedef struct packed {
        logic               is_free;
        logic [FIELD_W-1:0] size;
        logic [START_W-1:0] start;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> design/first_fit_block_allocator.sv
// first-fit heap allocator: block table in one ram, scanned one entry a cycle
// depends on ffba_pkg and ffba_ram
//
// channel  dir  handshake                  payload
// s_*      in   s_tvalid / s_tready        tdata: alloc_size, free_address; tuser: req_type
// m_*      out  m_tvalid / m_tready        tdata: payload_address; tuser: status
//
// a request scans the table from entry 0 upward and stops at the first hit, or after
// the last of block_count entries (at most MAX_BLOCKS, 256) when nothing matches.
// the single ram read port sets the pace, one table entry read and checked per cycle.
// an allocate of size zero skips the scan and goes straight to the result.
// i_rst_n is synchronous, active low; it empties the table (count and heap top to zero).
// the finished word sits in an output register; a new request is taken while it waits,
// and its result holds in the sequencer until the output register is free.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [13:0] alloc_size, [27:14] free_address
    input  logic                s_tuser,   // [0] req_type
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [13:0] payload_address
    output logic [1:0]          m_tuser    // [1:0] status
);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_END    = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]         r_state,    n_state;
    logic               r_req,      n_req;
    logic [FIELD_W-1:0] r_size,     n_size;
    logic [FIELD_W-1:0] r_addr,     n_addr;
    logic [CNT_W-1:0]   r_idx,      n_idx;
    logic               r_pend,     n_pend;
    logic [IDX_W-1:0]   r_pend_idx, n_pend_idx;
    logic [CNT_W-1:0]   r_count,    n_count;
    logic [TOP_W-1:0]   r_top,      n_top;
    logic [FIELD_W-1:0] r_res_addr, n_res_addr;
    logic [1:0]         r_res_stat, n_res_stat;
    logic               r_m_valid,  n_m_valid;
    logic [FIELD_W-1:0] r_m_addr,   n_m_addr;
    logic [1:0]         r_m_stat,   n_m_stat;

    // ram controls
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_entry;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_word;
    t_entry             rd_entry;

    // shared check unit
    logic [CMP_W-1:0]   rd_pay;
    logic [CMP_W-1:0]   top_pay;
    logic [SUM_W-1:0]   new_top;
    logic               hit;
    logic               s_fire;

    ffba_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word)
    );

    assign rd_entry = t_entry'(rd_word);
    assign s_tready = (r_state == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // entry check: payload address, fit test or address match
    assign rd_pay  = CMP_W'(rd_entry.start) + CMP_W'(HEADER_BYTES);
    assign top_pay = CMP_W'(r_top) + CMP_W'(HEADER_BYTES);
    assign new_top = SUM_W'(r_top) + SUM_W'(HEADER_BYTES) + SUM_W'(r_size);
    assign hit     = (r_req == REQ_ALLOC) ? (rd_entry.is_free && (rd_entry.size >= r_size))
                                          : (rd_pay == CMP_W'(r_addr));

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_size     = r_size;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_count    = r_count;
        n_top      = r_top;
        n_res_addr = r_res_addr;
        n_res_stat = r_res_stat;
        n_m_valid  = r_m_valid;
        n_m_addr   = r_m_addr;
        n_m_stat   = r_m_stat;
        wr_en      = 1'b0;
        wr_addr    = r_pend_idx;
        wr_entry   = rd_entry;
        rd_en      = 1'b0;
        rd_addr    = r_idx[IDX_W-1:0];

        // output register drains
        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_req  = s_tuser;
                    n_size = s_tdata[FIELD_W-1:0];
                    n_addr = s_tdata[2*FIELD_W-1:FIELD_W];
                    n_idx  = '0;
                    n_pend = 1'b0;
                    if (s_tuser == REQ_ALLOC && s_tdata[FIELD_W-1:0] == '0) begin
                        n_res_addr = '0;
                        n_res_stat = STAT_ZERO;
                        n_state    = S_RESULT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend && hit) begin
                    // claim or release the matching block
                    wr_en            = 1'b1;
                    wr_entry.is_free = (r_req == REQ_FREE);
                    n_res_addr       = (r_req == REQ_ALLOC) ? rd_pay[FIELD_W-1:0] : '0;
                    n_res_stat       = STAT_OK;
                    n_pend           = 1'b0;
                    n_state          = S_RESULT;
                end else if (r_idx < r_count) begin
                    // fetch the next entry
                    rd_en      = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                    n_idx      = r_idx + CNT_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_END;
                end
            end
            S_END: begin
                n_res_addr = '0;
                if (r_req == REQ_FREE) begin
                    n_res_stat = STAT_UNKNOWN;
                end else if (r_count == CNT_W'(MAX_BLOCKS) ||
                             new_top > SUM_W'(HEAP_BYTES)) begin
                    n_res_stat = STAT_NOSPACE;
                end else begin
                    // append a new block at the heap top
                    wr_en            = 1'b1;
                    wr_addr          = r_count[IDX_W-1:0];
                    wr_entry.is_free = 1'b0;
                    wr_entry.size    = r_size;
                    wr_entry.start   = r_top[START_W-1:0];
                    n_count          = r_count + CNT_W'(1);
                    n_top            = new_top[TOP_W-1:0];
                    n_res_addr       = top_pay[FIELD_W-1:0];
                    n_res_stat       = STAT_OK;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_addr  = r_res_addr;
                    n_m_stat  = r_res_stat;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_idx     <= '0;
            r_count   <= '0;
            r_top     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_top     <= n_top;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_size     <= n_size;
        r_addr     <= n_addr;
        r_pend_idx <= n_pend_idx;
        r_res_addr <= n_res_addr;
        r_res_stat <= n_res_stat;
        r_m_addr   <= n_m_addr;
        r_m_stat   <= n_m_stat;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = M_DATA_W'(r_m_addr);
    assign m_tuser  = r_m_stat;

    // table never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_BLOCKS))
        else $error("block count above table depth");

    // heap top stays inside the heap
    a_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= TOP_W'(HEAP_BYTES))
        else $error("heap top beyond heap end");

    // any refusal carries a zero address
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("refused result with nonzero address");

    // one request at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while busy");

endmodule

>>> design/ffba_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
